// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker in sgf_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, idle while reset is high.
`define SGF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define SGF_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hw/rtl/sgf_pkg.sv
// Shared widths, register indexes and types of the soft wall gravity force block.
package sgf_pkg;

   localparam int DATA_W     = 32;
   localparam int SIZE_W     = 31;
   localparam int AXES       = 3;
   localparam int WALLS      = 2 * AXES;
   localparam int POW_STEPS  = 5;
   localparam int PEN_W      = 34;
   localparam int M_W        = 37;
   localparam int M_LIM_LOG  = 36;
   localparam int TERM_W     = 35;
   localparam int CAP_LOG    = 34;
   localparam int WALL_K_W   = 9;
   localparam int WALL_K     = 500;
   localparam int BASE_W     = 33;
   localparam int SUM_W      = 37;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_SIZE_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GRAV_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GRAV_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GRAV_Z = 3'd5;

   typedef struct packed {
      logic zero;
      logic cap;
   } wall_flags_type;

endpackage

// File: hw/rtl/sgf_pen.sv
// Penetration stage: depth past both wall borders of one axis, classified and registered.
module sgf_pen #(
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [sgf_pkg::DATA_W-1:0]  pos,
   input  logic [sgf_pkg::SIZE_W-1:0]         size,
   output logic [FRAC_BITS+2:0]               p_lo,
   output logic [FRAC_BITS+2:0]               p_hi,
   output sgf_pkg::wall_flags_type            flags_lo,
   output sgf_pkg::wall_flags_type            flags_hi
);
   import sgf_pkg::*;

   localparam int PW = FRAC_BITS + 3;
   localparam logic signed [PEN_W-1:0] BORDER = PEN_W'(2 << FRAC_BITS);
   localparam logic signed [PEN_W-1:0] FAR    = PEN_W'(1 << PW);

   logic signed [PEN_W-1:0] pos_ext;
   logic signed [PEN_W-1:0] size_ext;
   logic signed [PEN_W-1:0] pen_lo;
   logic signed [PEN_W-1:0] pen_hi;
   logic [PW-1:0]           p_lo_ff, p_hi_ff;
   wall_flags_type          flags_lo_in, flags_hi_in;
   wall_flags_type          flags_lo_ff, flags_hi_ff;

   function automatic wall_flags_type classify(input logic signed [PEN_W-1:0] pen);
      wall_flags_type f;
      f.zero = pen[PEN_W-1] || (pen == '0);
      f.cap  = !f.zero && (pen >= FAR);
      return f;
   endfunction

   assign pos_ext  = $signed({{(PEN_W-DATA_W){pos[DATA_W-1]}}, pos});
   assign size_ext = $signed({{(PEN_W-SIZE_W){1'b0}}, size});
   assign pen_lo   = BORDER - pos_ext;
   assign pen_hi   = pos_ext - size_ext + BORDER;

   always_comb begin
      flags_lo_in = classify(pen_lo);
      flags_hi_in = classify(pen_hi);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_lo_ff     <= pen_lo[PW-1:0];
         p_hi_ff     <= pen_hi[PW-1:0];
         flags_lo_ff <= flags_lo_in;
         flags_hi_ff <= flags_hi_in;
      end
   end

   assign p_lo     = p_lo_ff;
   assign p_hi     = p_hi_ff;
   assign flags_lo = flags_lo_ff;
   assign flags_hi = flags_hi_ff;

endmodule

// File: hw/rtl/sgf_pow.sv
// One power step: m = min((m * p) >> FRAC_BITS, 2^36), registered with p and flags.
module sgf_pow #(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic [sgf_pkg::M_W-1:0]        m_i,
   input  logic [FRAC_BITS+2:0]           p_i,
   input  sgf_pkg::wall_flags_type        flags_i,
   output logic [sgf_pkg::M_W-1:0]        m_o,
   output logic [FRAC_BITS+2:0]           p_o,
   output sgf_pkg::wall_flags_type        flags_o
);
   import sgf_pkg::*;

   localparam int PW    = FRAC_BITS + 3;
   localparam int PRD_W = M_W + PW;
   localparam logic [PRD_W-1:0] M_LIM = PRD_W'(1) << M_LIM_LOG;

   logic [PRD_W-1:0] prod;
   logic [PRD_W-1:0] prod_sh;
   logic [M_W-1:0]   m_in;
   logic [M_W-1:0]   m_ff;
   logic [PW-1:0]    p_ff;
   wall_flags_type   flags_ff;

   assign prod    = {{PW{1'b0}}, m_i} * {{M_W{1'b0}}, p_i};
   assign prod_sh = prod >> FRAC_BITS;
   assign m_in    = (prod_sh > M_LIM) ? M_LIM[M_W-1:0] : prod_sh[M_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff     <= m_in;
         p_ff     <= p_i;
         flags_ff <= flags_i;
      end
   end

   assign m_o     = m_ff;
   assign p_o     = p_ff;
   assign flags_o = flags_ff;

endmodule

// File: hw/rtl/sgf_scale.sv
// Wall term: 500 * p^6 capped at 2^34, forced by the zero and far flags, registered.
module sgf_scale (
   input  logic                           clock,
   input  logic                           en,
   input  logic [sgf_pkg::M_W-1:0]        m_i,
   input  sgf_pkg::wall_flags_type        flags_i,
   output logic [sgf_pkg::TERM_W-1:0]     term
);
   import sgf_pkg::*;

   localparam int SC_W = M_W + WALL_K_W;
   localparam logic [SC_W-1:0]     K   = SC_W'(WALL_K);
   localparam logic [SC_W-1:0]     CAP = SC_W'(1) << CAP_LOG;

   logic [SC_W-1:0]   prod;
   logic [TERM_W-1:0] term_in;
   logic [TERM_W-1:0] term_ff;

   assign prod = {{WALL_K_W{1'b0}}, m_i} * K;

   always_comb begin
      if (flags_i.zero) begin
         term_in = '0;
      end else if (flags_i.cap || (prod > CAP)) begin
         term_in = CAP[TERM_W-1:0];
      end else begin
         term_in = prod[TERM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

// File: hw/rtl/soft_wall_gravity_force.sv
// Top level: soft wall and gravity force pipeline for one atom per item.
// Eight register stages: penetration, five power steps, wall scale, sum and saturate.
// Sustains one item per cycle whenever rsp is not stalled.
// The whole pipeline holds while rsp_tvalid is high and rsp_tready is low.
// Synchronous reset empties the pipeline and loads size 100.0 and zero gravity per axis.
module soft_wall_gravity_force #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // pos_x, pos_y, pos_z, force_x_in, force_y_in, force_z_in
   input  logic [2*sgf_pkg::AXES*sgf_pkg::DATA_W-1:0]  req_tdata,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // force_x_out, force_y_out, force_z_out
   output logic [sgf_pkg::AXES*sgf_pkg::DATA_W-1:0]    rsp_tdata,
   // saturated
   output logic [0:0]                                  rsp_tuser,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [sgf_pkg::CSR_IDX_W-1:0]               csr_index,
   input  logic [sgf_pkg::DATA_W-1:0]                  csr_wdata
);
   import sgf_pkg::*;

   localparam int PW       = FRAC_BITS + 3;
   localparam int SCALE_ST = POW_STEPS + 1;
   localparam int OUT_ST   = SCALE_ST + 1;
   localparam int NSTG     = OUT_ST + 1;
   localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(100 << FRAC_BITS);
   localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
   localparam logic signed [SUM_W-1:0] OUT_MIN = ~OUT_MAX;

   logic [SIZE_W-1:0]        size_ff [AXES];
   logic [DATA_W-1:0]        grav_ff [AXES];
   logic [NSTG-1:0]          v_ff;
   logic                     adv;
   logic signed [BASE_W-1:0] base_in [AXES];
   logic signed [BASE_W-1:0] base_ff [SCALE_ST+1][AXES];
   logic [DATA_W-1:0]        out_in  [AXES];
   logic [DATA_W-1:0]        out_ff  [AXES];
   logic                     sat_in, sat_ff;

   logic [M_W-1:0]           m_w  [WALLS][POW_STEPS+1];
   logic [PW-1:0]            p_w  [WALLS][POW_STEPS];
   wall_flags_type           f_w  [WALLS][POW_STEPS+1];
   logic [TERM_W-1:0]        term_w [WALLS];

   assign adv        = !v_ff[OUT_ST] || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            size_ff[a] <= SIZE_RST;
            grav_ff[a] <= '0;
         end
      end else if (csr_valid) begin
         case (csr_index)
            REG_SIZE_X: size_ff[0] <= csr_wdata[SIZE_W-1:0];
            REG_SIZE_Y: size_ff[1] <= csr_wdata[SIZE_W-1:0];
            REG_SIZE_Z: size_ff[2] <= csr_wdata[SIZE_W-1:0];
            REG_GRAV_X: grav_ff[0] <= csr_wdata;
            REG_GRAV_Y: grav_ff[1] <= csr_wdata;
            REG_GRAV_Z: grav_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NSTG-2:0], req_tvalid};
      end
   end

   // force_in + gravity, carried alongside the wall terms
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         base_in[a] = $signed({req_tdata[(AXES+a)*DATA_W+DATA_W-1],
                               req_tdata[(AXES+a)*DATA_W +: DATA_W]})
                    + $signed({grav_ff[a][DATA_W-1], grav_ff[a]});
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         base_ff[0] <= base_in;
         for (int s = 1; s <= SCALE_ST; s++) begin
            base_ff[s] <= base_ff[s-1];
         end
      end
   end

   for (genvar ga = 0; ga < AXES; ga++) begin : g_axis
      sgf_pen #(.FRAC_BITS(FRAC_BITS)) u_pen (
         .clock    (clock),
         .en       (adv),
         .pos      ($signed(req_tdata[ga*DATA_W +: DATA_W])),
         .size     (size_ff[ga]),
         .p_lo     (p_w[2*ga][0]),
         .p_hi     (p_w[2*ga+1][0]),
         .flags_lo (f_w[2*ga][0]),
         .flags_hi (f_w[2*ga+1][0])
      );
   end

   for (genvar gw = 0; gw < WALLS; gw++) begin : g_wall
      assign m_w[gw][0] = {{(M_W-PW){1'b0}}, p_w[gw][0]};

      for (genvar gs = 0; gs < POW_STEPS; gs++) begin : g_step
         if (gs < POW_STEPS - 1) begin : g_mid
            sgf_pow #(.FRAC_BITS(FRAC_BITS)) u_pow (
               .clock   (clock),
               .en      (adv),
               .m_i     (m_w[gw][gs]),
               .p_i     (p_w[gw][gs]),
               .flags_i (f_w[gw][gs]),
               .m_o     (m_w[gw][gs+1]),
               .p_o     (p_w[gw][gs+1]),
               .flags_o (f_w[gw][gs+1])
            );
         end else begin : g_last
            sgf_pow #(.FRAC_BITS(FRAC_BITS)) u_pow (
               .clock   (clock),
               .en      (adv),
               .m_i     (m_w[gw][gs]),
               .p_i     (p_w[gw][gs]),
               .flags_i (f_w[gw][gs]),
               .m_o     (m_w[gw][gs+1]),
               .p_o     (),
               .flags_o (f_w[gw][gs+1])
            );
         end
      end

      sgf_scale u_scale (
         .clock   (clock),
         .en      (adv),
         .m_i     (m_w[gw][POW_STEPS]),
         .flags_i (f_w[gw][POW_STEPS]),
         .term    (term_w[gw])
      );
   end

   // low wall pushes up, high wall pushes down; clip to 32 bits
   always_comb begin
      logic signed [SUM_W-1:0] sum;
      sat_in = 1'b0;
      for (int a = 0; a < AXES; a++) begin
         sum = $signed({{(SUM_W-BASE_W){base_ff[SCALE_ST][a][BASE_W-1]}},
                        base_ff[SCALE_ST][a]})
             + $signed({{(SUM_W-TERM_W){1'b0}}, term_w[2*a]})
             - $signed({{(SUM_W-TERM_W){1'b0}}, term_w[2*a+1]});
         if (sum > OUT_MAX) begin
            out_in[a] = OUT_MAX[DATA_W-1:0];
            sat_in    = 1'b1;
         end else if (sum < OUT_MIN) begin
            out_in[a] = OUT_MIN[DATA_W-1:0];
            sat_in    = 1'b1;
         end else begin
            out_in[a] = sum[DATA_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_tvalid   = v_ff[OUT_ST];
   assign rsp_tuser[0] = sat_ff;
   for (genvar go = 0; go < AXES; go++) begin : g_out
      assign rsp_tdata[go*DATA_W +: DATA_W] = out_ff[go];
   end

endmodule

// File: hw/rtl/sgf_checker.sv
// Port-level checker for the soft wall gravity force block, with its bind.
`include "assert_macros.svh"

module sgf_checker (
   input logic          clock,
   input logic          reset,
   input logic          req_tready,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [95:0]   rsp_tdata,
   input logic [0:0]    rsp_tuser
);

   logic        rsp_stall;
   logic [96:0] rsp_bits;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_bits  = {rsp_tuser, rsp_tdata};

   `SGF_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid, "rsp item dropped while stalled")
   `SGF_ASSERT(a_rsp_stable, rsp_stall |=> $stable(rsp_bits), "rsp item changed while stalled")
   `SGF_ASSERT(a_req_stall, !req_tready |-> rsp_stall, "req stalled without rsp backpressure")
   `SGF_ASSERT_RST(a_reset_empty, reset |=> !rsp_tvalid, "rsp valid right after reset")

endmodule

bind soft_wall_gravity_force sgf_checker u_sgf_checker (.*);
